>>> design/hill_cipher_3x3_mod26_assert.svh
// Assertion macros for the Hill cipher block. Each takes a label, an
// antecedent and a consequent and checks on the rising edge of clk while
// rst_n is high.
`ifndef HILL_CIPHER_3X3_MOD26_ASSERT_SVH
`define HILL_CIPHER_3X3_MOD26_ASSERT_SVH
`ifndef SYNTHESIS
`define HC3_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hc3 same-cycle check failed");
`define HC3_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hc3 next-cycle check failed");
`else
`define HC3_ASSERT_SAME(label, ante, cons)
`define HC3_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> design/hc3_pkg.sv
`default_nettype none
package hc3_pkg;

  localparam int LETTER_W = 5;
  localparam int KEY_W    = 45;
  localparam int DATA_W   = 16;

  localparam logic [LETTER_W-1:0] MODULUS = 5'd26;
  localparam logic [KEY_W-1:0]    KEY_RST = 45'd20962301613297;

  // Register indexes
  localparam logic CFG_KEY  = 1'b0;
  localparam logic CFG_MODE = 1'b1;

  // Depth of the key inversion pipeline
  localparam logic [2:0] KEY_LAT = 3'd7;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef letter_t [2:0]       vec3_t;
  typedef vec3_t [2:0]         mat_t;   // mat[row][col]
  typedef logic [9:0]          prod_t;
  typedef logic [11:0]         wide_t;

  typedef struct packed {
    mat_t coef;   // matrix the lanes multiply by
    logic bad;    // decrypting with a singular key
  } key_ctl_t;

  // Bring a 5-bit value into 0..25
  function automatic letter_t red26(input letter_t v);
    return (v >= MODULUS) ? letter_t'(v - MODULUS) : v;
  endfunction

  // 5x5 product, full width
  function automatic prod_t mul5(input letter_t a, input letter_t b);
    return {5'd0, a} * {5'd0, b};
  endfunction

  // Remainder by 26 through a reciprocal multiply; exact for all 12-bit inputs
  function automatic letter_t mod26(input wide_t v);
    logic [23:0] p;
    logic [7:0]  q;
    wide_t       qm;
    p  = {12'd0, v} * 24'd2521;
    q  = p[23:16];
    qm = 12'({4'd0, q} * 12'd26);
    return letter_t'(v - qm);
  endfunction

  // Multiplicative inverse mod 26, zero where none exists
  function automatic letter_t inv26(input letter_t d);
    letter_t r;
    case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/hc3_key_inv.sv
`default_nettype none
module hc3_key_inv
  import hc3_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [KEY_W-1:0] key_i,
  input  wire logic             mode_i,
  output key_ctl_t              ctl_o
);

  mat_t    mk1_r, mk2_r, mk3_r, mk4_r, mk5_r, mk6_r;
  prod_t   pa_r [3][3];
  prod_t   pb_r [3][3];
  mat_t    adj3_r, adj4_r, adj5_r;
  prod_t   dp_r [3];
  letter_t dinv_r;
  prod_t   ip_r [3][3];
  logic    sing6_r;
  key_ctl_t ctl_r;

  // Unpack and reduce the key entries
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mk1_r[r][c] <= red26(key_i[LETTER_W*(3*r+c) +: LETTER_W]);
      end
    end
  end

  // Cofactor products, two per adjugate entry
  always_ff @(posedge clk) begin
    mk2_r <= mk1_r;
    pa_r[0][0] <= mul5(mk1_r[1][1], mk1_r[2][2]);
    pb_r[0][0] <= mul5(mk1_r[2][1], mk1_r[1][2]);
    pa_r[0][1] <= mul5(mk1_r[0][2], mk1_r[2][1]);
    pb_r[0][1] <= mul5(mk1_r[0][1], mk1_r[2][2]);
    pa_r[0][2] <= mul5(mk1_r[0][1], mk1_r[1][2]);
    pb_r[0][2] <= mul5(mk1_r[1][1], mk1_r[0][2]);
    pa_r[1][0] <= mul5(mk1_r[1][2], mk1_r[2][0]);
    pb_r[1][0] <= mul5(mk1_r[1][0], mk1_r[2][2]);
    pa_r[1][1] <= mul5(mk1_r[0][0], mk1_r[2][2]);
    pb_r[1][1] <= mul5(mk1_r[2][0], mk1_r[0][2]);
    pa_r[1][2] <= mul5(mk1_r[0][2], mk1_r[1][0]);
    pb_r[1][2] <= mul5(mk1_r[0][0], mk1_r[1][2]);
    pa_r[2][0] <= mul5(mk1_r[1][0], mk1_r[2][1]);
    pb_r[2][0] <= mul5(mk1_r[1][1], mk1_r[2][0]);
    pa_r[2][1] <= mul5(mk1_r[0][1], mk1_r[2][0]);
    pb_r[2][1] <= mul5(mk1_r[0][0], mk1_r[2][1]);
    pa_r[2][2] <= mul5(mk1_r[0][0], mk1_r[1][1]);
    pb_r[2][2] <= mul5(mk1_r[1][0], mk1_r[0][1]);
  end

  // Adjugate entries; add 26*25 to keep the difference positive
  always_ff @(posedge clk) begin
    mk3_r <= mk2_r;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        adj3_r[r][c] <= mod26(wide_t'({2'b00, pa_r[r][c]} + 12'd650 - {2'b00, pb_r[r][c]}));
      end
    end
  end

  // Determinant terms along the first row
  always_ff @(posedge clk) begin
    mk4_r  <= mk3_r;
    adj4_r <= adj3_r;
    for (int k = 0; k < 3; k++) begin
      dp_r[k] <= mul5(mk3_r[0][k], adj3_r[k][0]);
    end
  end

  // Determinant mod 26 and its inverse
  always_ff @(posedge clk) begin
    mk5_r  <= mk4_r;
    adj5_r <= adj4_r;
    dinv_r <= inv26(mod26(wide_t'({2'b00, dp_r[0]} + {2'b00, dp_r[1]} + {2'b00, dp_r[2]})));
  end

  // Scale the adjugate
  always_ff @(posedge clk) begin
    mk6_r   <= mk5_r;
    sing6_r <= (dinv_r == 5'd0);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ip_r[r][c] <= mul5(adj5_r[r][c], dinv_r);
      end
    end
  end

  // Select the matrix for the lanes
  always_ff @(posedge clk) begin
    ctl_r.bad <= mode_i & sing6_r;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ctl_r.coef[r][c] <= mode_i ? mod26({2'b00, ip_r[r][c]}) : mk6_r[r][c];
      end
    end
  end

  assign ctl_o = ctl_r;

endmodule
`default_nettype wire

>>> design/hc3_lane.sv
`default_nettype none
module hc3_lane
  import hc3_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  en_i,
  input  wire vec3_t row_i,
  input  wire vec3_t col_i,
  output wide_t      sum_o
);

  wide_t sum_r;

  // Dot product of the row with one key column
  always_ff @(posedge clk) begin
    if (en_i) begin
      sum_r <= wide_t'({2'b00, mul5(row_i[0], col_i[0])}
                     + {2'b00, mul5(row_i[1], col_i[1])}
                     + {2'b00, mul5(row_i[2], col_i[2])});
    end
  end

  assign sum_o = sum_r;

endmodule
`default_nettype wire

>>> design/hill_cipher_3x3_mod26.sv
// Hill cipher engine over a 3x3 key mod 26. Each input item is one row of
// three letters (0..25); the result is the row times the key (encrypt) or
// times the inverse key mod 26 (decrypt). Items flow back to back at one
// per cycle while out_tready is high; the accepted row is registered,
// three column lanes form the dot products and a merge stage reduces them
// mod 26 into the output register. The inverse key is built by a seven
// stage pipeline from the key register, so after reset and after every
// configuration write in_tready stays low while it settles. When
// decrypting with a key whose determinant has no inverse mod 26, every
// result carries key_invalid set and zero letters.
`default_nettype none
module hill_cipher_3x3_mod26
  import hc3_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic              cfg_addr,
  input  wire logic [KEY_W-1:0]  cfg_wdata,
  // input row
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [DATA_W-1:0] in_tdata,  // letter_first, letter_second, letter_third, pad
  // result row
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [DATA_W-1:0]      out_tdata, // out_first, out_second, out_third, pad
  output logic                   out_tuser  // key_invalid
);

  `include "hill_cipher_3x3_mod26_assert.svh"

  logic [KEY_W-1:0] key_r;
  logic             mode_r;
  logic [2:0]       cnt_r, cnt_nxt;
  key_ctl_t         ctl;

  logic  rdy_o, rdy2, rdy1, in_fire;
  logic  v1_r, v2_r, vo_r;
  vec3_t row_r;
  vec3_t col [3];
  wide_t sum [3];
  vec3_t res_r;
  logic  inv_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= KEY_RST;
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_KEY) begin
        key_r <= cfg_wdata;
      end
      if (cfg_addr == CFG_MODE) begin
        mode_r <= cfg_wdata[0];
      end
    end
  end

  // Hold off input until the inverse key has settled
  always_comb begin
    if (cfg_we) begin
      cnt_nxt = KEY_LAT;
    end else if (cnt_r != 3'd0) begin
      cnt_nxt = cnt_r - 3'd1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= KEY_LAT;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  hc3_key_inv u_key_inv (
    .clk    (clk),
    .key_i  (key_r),
    .mode_i (mode_r),
    .ctl_o  (ctl)
  );

  // Per-stage ready chain
  assign rdy_o     = !vo_r || out_tready;
  assign rdy2      = !v2_r || rdy_o;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1 && (cnt_r == 3'd0);
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_fire;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy_o) begin
        vo_r <= v2_r;
      end
    end
  end

  // Capture and reduce the incoming row
  always_ff @(posedge clk) begin
    if (in_fire) begin
      row_r[0] <= red26(in_tdata[4:0]);
      row_r[1] <= red26(in_tdata[9:5]);
      row_r[2] <= red26(in_tdata[14:10]);
    end
  end

  // One lane per result column
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        col[j][k] = ctl.coef[k][j];
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_lane
    hc3_lane u_lane (
      .clk   (clk),
      .en_i  (rdy2 && v1_r),
      .row_i (row_r),
      .col_i (col[j]),
      .sum_o (sum[j])
    );
  end

  // Merge lanes: reduce, zero on a singular key, hold for the consumer
  always_ff @(posedge clk) begin
    if (rdy_o && v2_r) begin
      inv_r <= ctl.bad;
      for (int j = 0; j < 3; j++) begin
        res_r[j] <= ctl.bad ? 5'd0 : mod26(sum[j]);
      end
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {1'b0, res_r[2], res_r[1], res_r[0]};
  assign out_tuser  = inv_r;

  `HC3_ASSERT_SAME(a_settle_blocks_input, cnt_r != 3'd0, !in_tready)
  `HC3_ASSERT_SAME(a_invalid_zero_letters, out_tvalid && out_tuser, out_tdata == 16'd0)
  `HC3_ASSERT_NEXT(a_accept_fills_stage1, in_tvalid && in_tready, v1_r)

endmodule
`default_nettype wire
